>>> rtl/core/zel_pkg.sv
// Package for the zip end record locator.
// Holds record layout constants, scan limits and the result type.
// No dependencies.
package zel_pkg;

    // Record layout
    localparam int unsigned HdrBytes   = 22;
    localparam logic [31:0] EndSig     = 32'h0605_4b50;

    // Distance counter
    localparam int unsigned DistW      = 17;
    localparam logic [DistW-1:0] DistMax = {DistW{1'b1}};

    // Scan gives up at this distance
    localparam logic [DistW-1:0] MaxScanBytes = 17'd65557;

    typedef logic [7:0] byte_t;

    typedef struct packed {
        logic        found;
        logic [15:0] entry_count;
        logic [31:0] directory_offset;
        logic [31:0] directory_size;
    } zel_result_t;

endpackage

>>> rtl/core/zel_in_if.sv
// Input channel: one file byte per item, last byte of the file first.
// Depends on zel_pkg.
interface zel_in_if;
    import zel_pkg::*;

    logic  valid;
    logic  ready;
    byte_t data_byte;
    logic  final_byte;

    modport source (output valid, output data_byte, output final_byte, input ready);
    modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

>>> rtl/core/zel_out_if.sv
// Result channel: located end record or a not-found answer.
// No dependencies.
interface zel_out_if;
    logic        valid;
    logic        ready;
    logic        found;
    logic [15:0] entry_count;
    logic [31:0] directory_offset;
    logic [31:0] directory_size;

    modport source (output valid, output found, output entry_count,
                    output directory_offset, output directory_size, input ready);
    modport sink   (input valid, input found, input entry_count,
                    input directory_offset, input directory_size, output ready);
endinterface

>>> rtl/core/zel_scan.sv
// Byte window, distance counter and end record check.
// Depends on zel_pkg.
module zel_scan
    import zel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  byte_t       data_byte,
    input  logic        final_byte,
    output logic        res_valid,
    output zel_result_t res
);

    byte_t            window_reg [HdrBytes];
    byte_t            window_next [HdrBytes];
    logic [DistW-1:0] dist_reg;
    logic [DistW-1:0] dist_next;
    logic             done_reg;
    logic             done_next;

    logic [31:0] sig;
    logic [15:0] disk_a;
    logic [15:0] disk_b;
    logic [15:0] cnt_a;
    logic [15:0] cnt_b;
    logic [31:0] dir_size;
    logic [31:0] dir_offset;
    logic [15:0] comment_len;
    logic        fits;
    logic        ok;
    logic        limit_hit;

    // Window after shifting in the new byte (position 0 is the newest)
    always_comb
    begin
        window_next[0] = data_byte;
        for (int i = 1; i < HdrBytes; i++)
        begin
            window_next[i] = window_reg[i-1];
        end
    end

    // Saturating distance from the end of the file
    assign dist_next = (dist_reg == DistMax) ? dist_reg : dist_reg + 1'b1;

    // Little-endian record fields
    assign sig         = {window_next[3], window_next[2], window_next[1], window_next[0]};
    assign disk_a      = {window_next[5], window_next[4]};
    assign disk_b      = {window_next[7], window_next[6]};
    assign cnt_a       = {window_next[9], window_next[8]};
    assign cnt_b       = {window_next[11], window_next[10]};
    assign dir_size    = {window_next[15], window_next[14], window_next[13], window_next[12]};
    assign dir_offset  = {window_next[19], window_next[18], window_next[17], window_next[16]};
    assign comment_len = {window_next[21], window_next[20]};

    // Record plus comment must fit between this byte and the end
    assign fits = {1'b0, dist_next} >= ((DistW+1)'(comment_len) + (DistW+1)'(HdrBytes));

    assign ok = fits && (sig == EndSig) && (disk_a == 16'd0) && (disk_b == 16'd0)
             && (cnt_a == cnt_b) && (dir_size != 32'd0);

    assign limit_hit = (dist_next == MaxScanBytes);

    // Result for this byte
    always_comb
    begin
        res_valid = accept && !done_reg && (ok || final_byte || limit_hit);
        if (ok)
        begin
            res.found            = 1'b1;
            res.entry_count      = cnt_b;
            res.directory_offset = dir_offset;
            res.directory_size   = dir_size;
        end
        else
        begin
            res = '0;
        end
    end

    assign done_next = ok || limit_hit;

    // Control state; a final byte starts a fresh scan
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dist_reg <= '0;
            done_reg <= 1'b0;
        end
        else if (accept)
        begin
            if (final_byte)
            begin
                dist_reg <= '0;
                done_reg <= 1'b0;
            end
            else if (!done_reg)
            begin
                dist_reg <= dist_next;
                done_reg <= done_next;
            end
        end
    end

    // Window bytes; stale bytes are masked by the distance check
    always_ff @(posedge clk)
    begin
        if (accept && !done_reg)
        begin
            for (int i = 0; i < HdrBytes; i++)
            begin
                window_reg[i] <= window_next[i];
            end
        end
    end

    a_found_needs_full_record: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && res.found) |-> (dist_next >= DistW'(HdrBytes)))
        else $error("record found with fewer than a header of bytes");

    a_no_result_after_answer: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !res_valid)
        else $error("second result in one scan");

    a_final_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && final_byte) |=> (dist_reg == '0 && !done_reg))
        else $error("scan state not cleared after final byte");

endmodule

>>> rtl/core/zel_out_stage.sv
// Result register between the scan logic and the result channel.
// Depends on zel_pkg and zel_out_if.
module zel_out_stage
    import zel_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        res_valid,
    input  zel_result_t res,
    output logic        can_load,
    zel_out_if.source   result_out
);

    logic        valid_reg;
    zel_result_t res_reg;

    // Room when empty or when the held item leaves this cycle
    assign can_load = !valid_reg || result_out.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign result_out.valid            = valid_reg;
    assign result_out.found            = res_reg.found;
    assign result_out.entry_count      = res_reg.entry_count;
    assign result_out.directory_offset = res_reg.directory_offset;
    assign result_out.directory_size   = res_reg.directory_size;

endmodule

>>> rtl/core/zip_end_record_locator.sv
// Zip end record locator, top level.
// Depends on zel_pkg, zel_in_if, zel_out_if, zel_scan and zel_out_stage.
//
//   channel      dir   payload
//   item_in      in    data_byte[8], final_byte
//   result_out   out   found, entry_count[16], directory_offset[32], directory_size[32]
//
// One byte per cycle unless item_in stalls; the check on a byte is registered.
// A scan gives at most one result, at the byte that completes a valid record,
// at the final byte, or at the scan limit.
// Reset clears the distance counter, the answered flag and the result valid flag.
// item_in stalls only while a result waits in the output register and is not taken.
module zip_end_record_locator
    import zel_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    zel_in_if.sink    item_in,
    zel_out_if.source result_out
);

    logic        can_load;
    logic        accept;
    logic        res_valid;
    zel_result_t res;

    assign item_in.ready = can_load;
    assign accept        = item_in.valid && can_load;

    zel_scan u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (item_in.data_byte),
        .final_byte (item_in.final_byte),
        .res_valid  (res_valid),
        .res        (res)
    );

    zel_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .can_load   (can_load),
        .result_out (result_out)
    );

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps
// Testbench for the zip end record locator: feeds file tails last byte first
// and checks every answer against an in-bench model of the record search.
// Depends on zel_pkg, zel_in_if, zel_out_if and zip_end_record_locator.
module testbench;
    import zel_pkg::*;

    // Cycles with no accepted item on either channel before giving up
    localparam int unsigned StallLimit  = 5000;
    // Settling time after the last expected answer
    localparam int unsigned DrainCycles = 8;
    // Bytes of one idling phase of the random part
    localparam int unsigned PhaseItems  = 330;

    // Fields of one end record as laid out in the file
    typedef struct {
        logic [31:0] sig;
        logic [15:0] disk;
        logic [15:0] cd_disk;
        logic [15:0] n_disk;
        logic [15:0] n_total;
        logic [31:0] size;
        logic [31:0] offset;
        logic [15:0] clen;
    } end_rec_t;

    logic clk = 1'b0;
    logic rst_n;

    zel_in_if  in_ch ();
    zel_out_if out_ch ();

    zip_end_record_locator dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (in_ch),
        .result_out (out_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Search model state
    byte_t            scan_window [HdrBytes];
    logic [DistW-1:0] scan_dist;
    logic             scan_answered;
    zel_result_t      predicted_answers [$];

    // File tail under construction, earliest byte at index 0
    byte_t            tail_bytes [$];

    int unsigned answers_checked = 0;
    int unsigned mismatch_count  = 0;
    int unsigned items_sent      = 0;
    int unsigned tx_idle_pct     = 0;
    int unsigned rx_idle_pct     = 0;
    int unsigned hold_request    = 0;
    int unsigned hold_left       = 0;
    int unsigned stall_cycles    = 0;

    // ------------------------------------------------------------------
    // Search model
    // ------------------------------------------------------------------
    function automatic logic [15:0] window_le16(int unsigned at);
        return {scan_window[at + 1], scan_window[at]};
    endfunction

    function automatic logic [31:0] window_le32(int unsigned at);
        return {window_le16(at + 2), window_le16(at)};
    endfunction

    task automatic clear_scan();
        int i;
        for (i = 0; i < HdrBytes; i++)
            scan_window[i] = '0;
        scan_dist     = '0;
        scan_answered = 1'b0;
    endtask

    // One accepted byte: shift, test the window, queue any answer
    task automatic locate_step(input byte_t b, input logic last);
        zel_result_t answer;
        logic        hit;
        int unsigned dist_u;
        int          i;
        if (!scan_answered)
        begin
            for (i = HdrBytes - 1; i > 0; i--)
                scan_window[i] = scan_window[i - 1];
            scan_window[0] = b;
            if (scan_dist != DistMax)
                scan_dist = scan_dist + 1'b1;
            dist_u = 32'(scan_dist);
            hit = (dist_u >= HdrBytes)
                && (window_le32(0) == EndSig)
                && (dist_u - HdrBytes >= window_le16(20))
                && (window_le16(4) == 16'd0)
                && (window_le16(6) == 16'd0)
                && (window_le16(8) == window_le16(10))
                && (window_le32(12) != 32'd0);
            if (hit)
            begin
                answer.found            = 1'b1;
                answer.entry_count      = window_le16(10);
                answer.directory_offset = window_le32(16);
                answer.directory_size   = window_le32(12);
                predicted_answers.push_back(answer);
                scan_answered = 1'b1;
            end
            else if (last || scan_dist == MaxScanBytes)
            begin
                // not found: earliest byte reached or scan limit hit
                answer = '0;
                predicted_answers.push_back(answer);
                scan_answered = 1'b1;
            end
        end
        if (last)
            clear_scan();
    endtask

    // ------------------------------------------------------------------
    // Byte source
    // ------------------------------------------------------------------
    task automatic send_item(input byte_t b, input logic last);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.data_byte  <= b;
        in_ch.final_byte <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        locate_step(b, last);
        items_sent++;
    endtask

    // Feed the built tail from its end backward, final mark on the earliest byte
    task automatic feed_tail();
        int i;
        for (i = tail_bytes.size() - 1; i >= 0; i--)
            send_item(tail_bytes[i], i == 0);
        tail_bytes.delete();
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (predicted_answers.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Tail construction
    // ------------------------------------------------------------------
    task automatic add_random(input int unsigned n);
        repeat (n) tail_bytes.push_back(byte_t'($urandom_range(0, 255)));
    endtask

    task automatic add_le(input logic [31:0] value, input int unsigned nbytes);
        int unsigned k;
        for (k = 0; k < nbytes; k++)
            tail_bytes.push_back(value[8*k +: 8]);
    endtask

    task automatic add_record(input end_rec_t r);
        add_le(r.sig, 4);
        add_le(32'(r.disk), 2);
        add_le(32'(r.cd_disk), 2);
        add_le(32'(r.n_disk), 2);
        add_le(32'(r.n_total), 2);
        add_le(r.size, 4);
        add_le(r.offset, 4);
        add_le(32'(r.clen), 2);
    endtask

    function automatic end_rec_t good_record();
        end_rec_t r;
        r.sig     = EndSig;
        r.disk    = '0;
        r.cd_disk = '0;
        r.n_disk  = 16'($urandom);
        r.n_total = r.n_disk;
        r.size    = $urandom;
        if (r.size == 32'd0)
            r.size = 32'd1;
        r.offset  = $urandom;
        r.clen    = '0;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Answer sink: check, then pick ready for the next cycle
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : answer_check
        zel_result_t got;
        zel_result_t want;
        if (out_ch.valid && out_ch.ready)
        begin
            got = {out_ch.found, out_ch.entry_count,
                   out_ch.directory_offset, out_ch.directory_size};
            if (predicted_answers.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected answer: found=%0b entries=%h offset=%h size=%h",
                             got.found, got.entry_count, got.directory_offset,
                             got.directory_size);
            end
            else
            begin
                want = predicted_answers.pop_front();
                answers_checked++;
                if (got.found !== want.found || got.entry_count !== want.entry_count
                    || got.directory_offset !== want.directory_offset
                    || got.directory_size !== want.directory_size)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("answer mismatch: expected found=%0b entries=%h offset=%h size=%h",
                                 want.found, want.entry_count, want.directory_offset,
                                 want.directory_size);
                        $display("                 actual   found=%0b entries=%h offset=%h size=%h",
                                 got.found, got.entry_count, got.directory_offset,
                                 got.directory_size);
                    end
                end
            end
        end
        // long hold-off takes priority over random idling
        if (hold_request != 0)
        begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0)
        begin
            hold_left--;
            out_ch.ready <= 1'b0;
        end
        else
            out_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog on progress of either channel
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= StallLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Valid record with no comment; earlier bytes after it are ignored
    task automatic test_plain_record();
        add_random(5);
        add_record(good_record());
        feed_tail();
    endtask

    // Field extremes, comment that fits exactly, record on the final byte
    task automatic test_field_extremes();
        end_rec_t r;
        r         = good_record();
        r.n_disk  = 16'hffff;
        r.n_total = 16'hffff;
        r.size    = 32'hffff_ffff;
        r.offset  = 32'hffff_ffff;
        r.clen    = 16'd3;
        add_random(2);
        add_record(r);
        add_random(3);
        feed_tail();

        r         = good_record();
        r.n_disk  = '0;
        r.n_total = '0;
        r.size    = 32'd1;
        r.offset  = '0;
        add_record(r);
        feed_tail();
    endtask

    // Each acceptance rule broken on its own gives not-found at the final byte
    task automatic test_rule_breaks();
        end_rec_t r;
        int unsigned rule;
        for (rule = 0; rule < 6; rule++)
        begin
            r = good_record();
            case (rule)
                0: r.sig     = r.sig ^ (32'd1 << $urandom_range(0, 31));
                1: r.disk    = 16'($urandom_range(1, 65535));
                2: r.cd_disk = 16'($urandom_range(1, 65535));
                3: r.n_total = r.n_disk ^ (16'd1 << $urandom_range(0, 15));
                4: r.size    = '0;
                default: r.clen = 16'd2;
            endcase
            add_random(2);
            add_record(r);
            // one comment byte short when the length is the broken rule
            add_random(rule == 5 ? 1 : 0);
            feed_tail();
        end
    endtask

    // Fewer than 22 bytes can never hold a record
    task automatic test_short_tail();
        add_random(1);
        feed_tail();
        add_record(good_record());
        void'(tail_bytes.pop_back());
        feed_tail();
    endtask

    // The record nearest the end wins; a broken nearer one does not hide an older one
    task automatic test_nearest_record();
        end_rec_t r;
        add_record(good_record());
        add_record(good_record());
        feed_tail();

        add_record(good_record());
        r      = good_record();
        r.disk = 16'd1;
        add_record(r);
        feed_tail();
    endtask

    // Receiver holds off while short scans keep coming, then the source waits
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_idle_pct  = 0;
        hold_request = 400;
        repeat (12)
        begin
            add_random(2);
            feed_tail();
        end
        wait_drained();
    endtask

    task automatic random_scan();
        end_rec_t    r;
        int unsigned kind;
        int unsigned span;
        kind = $urandom_range(0, 9);
        if (kind == 0)
            add_random($urandom_range(1, 21));
        else if (kind == 1)
            add_random($urandom_range(22, 60));
        else
        begin
            add_random($urandom_range(0, 6));
            if ($urandom_range(0, 3) == 0)
            begin
                add_record(good_record());
                add_random($urandom_range(0, 4));
            end
            r       = good_record();
            span    = $urandom_range(0, 12);
            r.clen  = 16'($urandom_range(0, span));
            case ($urandom_range(0, 11))
                0: r.sig     = r.sig ^ (32'd1 << $urandom_range(0, 31));
                1: r.disk    = 16'($urandom_range(1, 65535));
                2: r.cd_disk = 16'($urandom_range(1, 65535));
                3: r.n_total = r.n_disk ^ (16'd1 << $urandom_range(0, 15));
                4: r.size    = '0;
                5: r.clen    = 16'(span + 1);
                default: ;
            endcase
            add_record(r);
            add_random(span);
        end
        feed_tail();
    endtask

    // Random scans over three idling mixes
    task automatic test_random_scans();
        int unsigned phase;
        int unsigned item_goal;
        int unsigned answer_goal;
        for (phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 8;
                    rx_idle_pct = 83;
                end
                1:
                begin
                    tx_idle_pct = 83;
                    rx_idle_pct = 8;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            item_goal   = items_sent + PhaseItems;
            answer_goal = answers_checked + predicted_answers.size() + 8;
            while (items_sent < item_goal
                   || answers_checked + predicted_answers.size() < answer_goal)
                random_scan();
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.data_byte  = '0;
        in_ch.final_byte = 1'b0;
        clear_scan();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        tx_idle_pct = 8;
        rx_idle_pct = 83;
        test_plain_record();
        test_field_extremes();
        test_rule_breaks();
        test_short_tail();
        test_nearest_record();
        wait_drained();
        test_backpressure();
        test_random_scans();
        wait_drained();

        if (mismatch_count == 0 && predicted_answers.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
